// ===== hw/rtl/mscf_pkg.sv =====
`default_nettype none

package mscf_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int CH_W   = 5;
    localparam int CODE_W = 8;
    localparam int OUT_W  = 16;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // frame phases
    localparam int PH_START_HI   = 0;
    localparam int PH_START_LO   = 1;
    localparam int PH_BIT_FIRST  = 2;
    localparam int PH_BIT_LAST   = 8;
    localparam int PH_STOP_HI    = 9;
    localparam int PH_DRIVE_LAST = 10;

    // code that marks an output as disabled
    localparam logic [CODE_W-1:0] CODE_OFF = 8'hFF;

    typedef struct packed {
        logic signed [CODE_W-1:0] code_value;
        logic [CH_W-1:0]          channel;
        logic [CMD_W-1:0]         cmd;
    } t_item;

    typedef struct packed {
        logic             drive_valid;
        logic [OUT_W-1:0] level_bits;
        logic [OUT_W-1:0] drive_mask;
        logic [OUT_W-1:0] active_mask;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/mscf_core.sv =====
`default_nettype none

module mscf_core #(
    parameter int NUM_OUTPUTS = 16,
    parameter int FRAME_TICKS = 30
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire mscf_pkg::t_item  i_item,
    output mscf_pkg::t_result     o_result
);
    import mscf_pkg::*;

    localparam int PW = $clog2(FRAME_TICKS);

    logic [CODE_W-1:0] r_cur  [NUM_OUTPUTS];
    logic [CODE_W-1:0] n_cur  [NUM_OUTPUTS];
    logic [CODE_W-1:0] r_pend [NUM_OUTPUTS];
    logic [CODE_W-1:0] n_pend [NUM_OUTPUTS];
    logic [PW-1:0]     r_phase;
    logic [PW-1:0]     n_phase;

    t_cmd             cmd;
    logic [PW-1:0]    ph_off;
    logic [2:0]       bit_sel;
    logic             ph_high;
    logic             ph_data;
    logic             drv_valid;
    logic [OUT_W-1:0] levels;
    logic [OUT_W-1:0] drive;
    logic [OUT_W-1:0] active;

    // phase decode, shared by all outputs
    always_comb begin
        ph_off  = r_phase - PW'(PH_BIT_FIRST);
        bit_sel = ph_off[2:0];
        ph_high = (r_phase == PW'(PH_START_HI)) || (r_phase == PW'(PH_STOP_HI));
        ph_data = (r_phase >= PW'(PH_BIT_FIRST)) && (r_phase <= PW'(PH_BIT_LAST));
    end

    always_comb begin
        cmd       = t_cmd'(i_item.cmd);
        n_cur     = r_cur;
        n_pend    = r_pend;
        n_phase   = r_phase;
        drv_valid = 1'b0;
        levels    = '0;
        drive     = '0;
        unique case (cmd)
            CMD_TICK: begin
                if (r_phase <= PW'(PH_DRIVE_LAST)) begin
                    drv_valid = 1'b1;
                    for (int i = 0; i < NUM_OUTPUTS; i++) begin
                        drive[i]  = ~r_cur[i][CODE_W-1];
                        levels[i] = ph_high || (ph_data && !r_cur[i][bit_sel]);
                    end
                end
                // frame wrap: pending codes take over
                if (r_phase == PW'(FRAME_TICKS - 1)) begin
                    n_phase = '0;
                    n_cur   = r_pend;
                end else begin
                    n_phase = r_phase + PW'(1);
                end
            end
            CMD_SET: begin
                for (int i = 0; i < NUM_OUTPUTS; i++) begin
                    if (i_item.channel == CH_W'(i)) begin
                        // disable code on an active output stops it now
                        if (!r_cur[i][CODE_W-1] && (i_item.code_value == CODE_OFF)) begin
                            n_cur[i] = CODE_OFF;
                        end
                        n_pend[i] = i_item.code_value;
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < NUM_OUTPUTS; i++) begin
                    n_cur[i]  = CODE_OFF;
                    n_pend[i] = CODE_OFF;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        active = '0;
        for (int i = 0; i < NUM_OUTPUTS; i++) begin
            active[i] = ~n_cur[i][CODE_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                r_cur[i]  <= CODE_OFF;
                r_pend[i] <= CODE_OFF;
            end
            r_phase <= '0;
        end else if (i_step) begin
            r_cur   <= n_cur;
            r_pend  <= n_pend;
            r_phase <= n_phase;
        end
    end

    assign o_result = '{drive_valid: drv_valid, level_bits: levels,
                        drive_mask: drive, active_mask: active};

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_signal_code_framer_top.sv =====
// Pipeline: a transaction accepted on the slave side passes the input register, then
//   the result register, before its result shows on the master side.
// Throughput: one transaction per cycle while the master side takes results; every command kind alike.
// Reset (i_rst_n low, synchronous): all outputs inactive, pending codes off,
//   frame phase 0, both pipeline stages empty.
`default_nettype none

module multichannel_signal_code_framer_top #(
    parameter int NUM_OUTPUTS = 16,  // 1..16
    parameter int FRAME_TICKS = 30   // 11..64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [4:0] channel, [12:5] code_value, rest zero
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // [15:0] level_bits, [31:16] drive_mask,
                                               // [47:32] active_mask
    output logic [0:0]       o_m_axis_tuser    // [0] drive_valid
);
    import mscf_pkg::*;

    // Two-stage pipe: input register feeds the framer core, whose result is
    // captured in the output register together with the state update.
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;

    logic advance;
    logic in_acc;
    logic step;

    // output stage can take a new result when empty or being drained
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    // state commits exactly when the held command moves into the result register
    assign step            = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= '{code_value: i_s_axis_tdata[12:5],
                      channel:    i_s_axis_tdata[4:0],
                      cmd:        i_s_axis_tuser};
        end
    end

    mscf_core #(
        .NUM_OUTPUTS (NUM_OUTPUTS),
        .FRAME_TICKS (FRAME_TICKS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.active_mask, r_out.drive_mask, r_out.level_bits};
    assign o_m_axis_tuser  = r_out.drive_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/mscf_checker.sv =====
`default_nettype none

module mscf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [15:0] i_s_axis_tdata,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [47:0] o_m_axis_tdata,
    input wire logic [0:0]  o_m_axis_tuser
);

    // a result that does not drive carries no levels and no drive mask
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[31:0] == 32'd0))
        else $error("non-driving result with nonzero levels or drive mask");

    // pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed or dropped");

    // while the result side stays stalled with both stages full, input stays blocked
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready && !o_s_axis_tready) |=>
            (!i_m_axis_tready |-> !o_s_axis_tready))
        else $error("input accepted while both stages full");

endmodule

bind multichannel_signal_code_framer_top mscf_checker u_mscf_checker (.*);

`default_nettype wire

// ===== sim/multichannel_signal_code_framer_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams, predicts each result from the accepted commands and
// compares the results in order.
module multichannel_signal_code_framer_checker
    import mscf_pkg::*;
#(
    parameter int NUM_OUTPUTS = 16,
    parameter int FRAME_TICKS = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [4:0] channel, [12:5] code_value
    input  wire logic [1:0]  i_s_tuser,   // [1:0] cmd
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [47:0] i_m_tdata,   // [15:0] level_bits, [31:16] drive_mask,
                                          // [47:32] active_mask
    input  wire logic [0:0]  i_m_tuser,   // [0] drive_valid
    output int               o_fail_count,
    output int               o_pending
);

    logic [CODE_W-1:0] code_now  [OUT_W];
    logic [CODE_W-1:0] code_next [OUT_W];
    // wide enough that phase + 1 reaches FRAME_TICKS without wrapping
    logic [7:0]        tick_phase;

    t_result expected_frames_q[$];
    int      fail_count = 0;

    function automatic void reset_framer();
        for (int i = 0; i < OUT_W; i++) begin
            code_now[i]  = CODE_OFF;
            code_next[i] = CODE_OFF;
        end
        tick_phase = '0;
    endfunction

    // sign bit clear = output is sending
    function automatic logic [OUT_W-1:0] active_outputs();
        logic [OUT_W-1:0] mask;
        mask = '0;
        for (int i = 0; i < NUM_OUTPUTS; i++)
            mask[i] = ~code_now[i][CODE_W-1];
        return mask;
    endfunction

    function automatic t_result step_framer(input t_item cmd_in);
        t_result res;
        int      ch;
        res = '0;
        ch  = cmd_in.channel;
        case (cmd_in.cmd)
            CMD_TICK: begin
                if (tick_phase <= PH_DRIVE_LAST) begin
                    res.drive_valid = 1'b1;
                    res.drive_mask  = active_outputs();
                    // levels come from the stored code even on inactive outputs
                    for (int i = 0; i < NUM_OUTPUTS; i++) begin
                        if (tick_phase == PH_START_HI || tick_phase == PH_STOP_HI)
                            res.level_bits[i] = 1'b1;
                        else if (tick_phase >= PH_BIT_FIRST && tick_phase <= PH_BIT_LAST)
                            res.level_bits[i] = ~code_now[i][tick_phase - PH_BIT_FIRST];
                    end
                end
                tick_phase = tick_phase + 8'd1;
                if (tick_phase >= FRAME_TICKS) begin
                    tick_phase = '0;
                    code_now   = code_next;
                end
            end
            CMD_SET: begin
                if (ch < NUM_OUTPUTS) begin
                    // only an exact -1 cuts an active output off mid-frame
                    if (!code_now[ch][CODE_W-1] && $unsigned(cmd_in.code_value) == CODE_OFF)
                        code_now[ch] = CODE_OFF;
                    code_next[ch] = cmd_in.code_value;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < OUT_W; i++) begin
                    code_now[i]  = CODE_OFF;
                    code_next[i] = CODE_OFF;
                end
            end
            default: ;
        endcase
        res.active_mask = active_outputs();
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_item   cmd_in;
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            reset_framer();
            expected_frames_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                cmd_in.cmd        = i_s_tuser;
                cmd_in.channel    = i_s_tdata[4:0];
                cmd_in.code_value = i_s_tdata[12:5];
                expected_frames_q.push_back(step_framer(cmd_in));
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.drive_valid = i_m_tuser[0];
                seen.level_bits  = i_m_tdata[15:0];
                seen.drive_mask  = i_m_tdata[31:16];
                seen.active_mask = i_m_tdata[47:32];
                if (expected_frames_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result valid=%0d levels=%h drive=%h active=%h",
                                 $realtime, seen.drive_valid, seen.level_bits,
                                 seen.drive_mask, seen.active_mask);
                end else begin
                    want = expected_frames_q.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch expected valid=%0d levels=%h drive=%h ",
                                      "active=%h, got valid=%0d levels=%h drive=%h active=%h"},
                                     $realtime, want.drive_valid, want.level_bits,
                                     want.drive_mask, want.active_mask, seen.drive_valid,
                                     seen.level_bits, seen.drive_mask, seen.active_mask);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_frames_q.size();
    end

endmodule

// ===== sim/multichannel_signal_code_framer_top_tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the framer. The checker instance beside the DUT
// does all prediction and comparison; this module only feeds commands,
// throttles the result side and decides pass or fail at the end.
module multichannel_signal_code_framer_top_tb;
    import mscf_pkg::*;

    localparam int NUM_OUTPUTS  = 16;
    localparam int FRAME_TICKS  = 30;
    localparam int RANDOM_ITEMS = 1700;

    // the cmd field is 2 bits wide; this code has no meaning and must be ignored
    localparam logic [CMD_W-1:0]  CMD_RESERVED = 2'd3;
    // most negative code: stored as pending but never disables at once
    localparam logic [CODE_W-1:0] CODE_NEG_MIN = 8'h80;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;

    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [47:0] m_tdata;
    wire logic [0:0]  m_tuser;

    int fail_count;
    int pending;

    // idle rates in percent, changed between stimulus phases
    int send_idle_pct  = 25;
    int recv_stall_pct = 58;

    // 8 ns period
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    multichannel_signal_code_framer_top #(
        .NUM_OUTPUTS(NUM_OUTPUTS),
        .FRAME_TICKS(FRAME_TICKS)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    multichannel_signal_code_framer_checker #(
        .NUM_OUTPUTS(NUM_OUTPUTS),
        .FRAME_TICKS(FRAME_TICKS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Result side back-pressure: a fresh coin every cycle, so stalls land on
    // every frame phase. With recv_stall_pct at zero tready stays high.
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic t_item make_cmd(input logic [CMD_W-1:0] cmd, input int ch,
                                       input logic [CODE_W-1:0] code);
        t_item it;
        it.cmd        = cmd;
        it.channel    = CH_W'(ch);
        it.code_value = code;
        return it;
    endfunction

    // Mostly ticks, so frames wrap often and pending codes go live; sets
    // mostly hit valid channels with well-formed codes, plus some -1 disables,
    // raw 8-bit codes, out-of-range channels, rare clears and reserved commands.
    function automatic t_item random_command();
        t_item       it;
        int unsigned pick;
        pick          = $urandom_range(0, 99);
        it.channel    = CH_W'($urandom_range(0, 31));
        it.code_value = CODE_W'($urandom_range(0, 255));
        if (pick < 68) begin
            it.cmd = CMD_TICK;
        end else if (pick < 94) begin
            it.cmd = CMD_SET;
            if ($urandom_range(0, 9) != 0)
                it.channel = CH_W'($urandom_range(0, NUM_OUTPUTS - 1));
            case ($urandom_range(0, 4))
                0:       it.code_value = CODE_OFF;
                1:       ;  // keep the full 8-bit random code
                default: it.code_value = CODE_W'($urandom_range(0, 127));
            endcase
        end else if (pick < 96) begin
            it.cmd = CMD_CLEAR;
        end else begin
            it.cmd = CMD_RESERVED;
        end
        return it;
    endfunction

    // One transaction on the command stream: optional idle cycles first, then
    // hold tvalid until the DUT takes it. tvalid stays up for back-to-back
    // commands; the caller drops it at the very end.
    task automatic send_cmd(input t_item it);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.code_value, it.channel};
        s_tuser  <= it.cmd;
        do @(posedge clk); while (!s_tready);
    endtask

    initial begin
        t_item cmd;
        int    counted;

        // synchronous reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reserved command, a tick with nothing active (phase 0 still
        // drives every level high with all outputs off), sets at the code and channel
        // extremes, a negative non-disable code, -1 on an inactive output,
        // out-of-range channels, then ticks through the driven phases into
        // the quiet part, a clear and one more set
        send_cmd(make_cmd(CMD_RESERVED, 31, CODE_OFF));
        send_cmd(make_cmd(CMD_TICK, 0, 8'h00));
        send_cmd(make_cmd(CMD_SET, 0, 8'h00));
        send_cmd(make_cmd(CMD_SET, NUM_OUTPUTS - 1, 8'h7F));
        send_cmd(make_cmd(CMD_SET, 7, 8'h55));
        send_cmd(make_cmd(CMD_SET, 3, CODE_NEG_MIN));
        send_cmd(make_cmd(CMD_SET, 4, CODE_OFF));
        send_cmd(make_cmd(CMD_SET, NUM_OUTPUTS, 8'h2A));
        send_cmd(make_cmd(CMD_SET, 31, 8'h7F));
        repeat (PH_DRIVE_LAST + 1)
            send_cmd(make_cmd(CMD_TICK, 31, CODE_OFF));
        send_cmd(make_cmd(CMD_CLEAR, 0, 8'h00));
        send_cmd(make_cmd(CMD_SET, 9, 8'h01));

        // random: three idle profiles; ignored commands don't count
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted == RANDOM_ITEMS / 3) begin
                send_idle_pct  = 58;
                recv_stall_pct = 25;
            end else if (counted == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            cmd = random_command();
            send_cmd(cmd);
            if (!(cmd.cmd == CMD_RESERVED ||
                  (cmd.cmd == CMD_SET && cmd.channel >= NUM_OUTPUTS)))
                counted++;
        end
        s_tvalid <= 1'b0;

        // drain: the checker's pending count is registered, so step once first
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
